[rtl/cubic_bezier_easing_assert.svh]
// assertion macros for the easing block checkers
`ifndef CUBIC_BEZIER_EASING_ASSERT_SVH
`define CUBIC_BEZIER_EASING_ASSERT_SVH

// explicit clock and active-low reset
`define CBE_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// default clock and reset of the block
`define CBE_ASSERT(lbl, prop, msg) `CBE_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[rtl/cbe_pkg.sv]
`timescale 1ns / 1ps

package cbe_pkg;

  localparam int QB       = 28;
  localparam int W        = 36;
  localparam int QUO_BITS = QB + 2;

  typedef logic signed [W-1:0] qv_t;
  typedef logic        [QB:0]  uq_t;

  localparam qv_t QONE = qv_t'(1) <<< QB;
  localparam qv_t EPS  = qv_t'(268);

  localparam logic [1:0] REG_X1 = 2'd0;
  localparam logic [1:0] REG_Y1 = 2'd1;
  localparam logic [1:0] REG_X2 = 2'd2;
  localparam logic [1:0] REG_Y2 = 2'd3;

  typedef struct packed {
    logic load;
    logic step;
  } mac_ctl_t;

  typedef struct packed {
    logic                done;
    logic                ovf;
    logic [QUO_BITS-1:0] quo;
  } div_res_t;

  function automatic logic abs_below_eps(qv_t v);
    return (v < EPS) && (v > -EPS);
  endfunction

endpackage

[rtl/cbe_mac.sv]
`timescale 1ns / 1ps

module cbe_mac
  import cbe_pkg::*;
(
  input  logic     clk_i,
  input  mac_ctl_t ctl_i,
  input  qv_t      init_i,
  input  qv_t      addend_i,
  input  uq_t      mult_i,
  output qv_t      acc_o
);

  logic signed [W+QB+1:0] prod;
  qv_t acc_d, acc_q;

  // floor of acc * u / 2^28, then the next horner coefficient
  assign prod = acc_q * $signed({1'b0, mult_i});

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.load) begin
      acc_d = init_i;
    end else if (ctl_i.step) begin
      acc_d = $signed(prod[QB +: W]) + addend_i;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

[rtl/cbe_div.sv]
`timescale 1ns / 1ps

module cbe_div
  import cbe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output div_res_t     res_o
);

  localparam int CW = $clog2(QUO_BITS + 1);
  localparam int SH = QUO_BITS - QB;

  logic [CW-1:0]       cnt_d, cnt_q;
  logic                done_d, done_q;
  logic [W-1:0]        rem_d, rem_q, den_d, den_q;
  logic [QUO_BITS-1:0] low_d, low_q, quo_d, quo_q;
  logic                ovf_d, ovf_q;
  logic [W:0]          trial, diff;

  // restoring division of num * 2^28 by den, one quotient bit a cycle
  always_comb begin
    trial  = {rem_q, low_q[QUO_BITS-1]};
    diff   = trial - {1'b0, den_q};
    cnt_d  = cnt_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      rem_d = num_i >> SH;
      low_d = {num_i[SH-1:0], {QB{1'b0}}};
      den_d = den_i;
      ovf_d = (num_i >> SH) >= den_i;
      quo_d = '0;
      cnt_d = CW'(QUO_BITS);
    end else if (cnt_q != '0) begin
      low_d = low_q << 1;
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[QUO_BITS-2:0], 1'b1};
      end else begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[QUO_BITS-2:0], 1'b0};
      end
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    low_q <= low_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign res_o = '{done: done_q, ovf: ovf_q, quo: quo_q};

endmodule

[rtl/cubic_bezier_easing.sv]
`timescale 1ns / 1ps
// cubic-bezier easing: maps progress x (unsigned, 1.0 = 2^FRAC_BITS) to the
// eased value y of the curve with control points (x1,y1), (x2,y2).
// input channel: progress_valid_i / progress_stall_o / progress_i, one beat
//   per item; stall is high while an item is being solved.
// output channel: eased_valid_o / eased_stall_i / eased_o, one beat per item,
//   held in an output register; the next item may be taken while it waits.
// config port: cfg_we_i, cfg_idx_i, cfg_data_i; write only while idle.
//   index 0 x1, 1 y1, 2 x2, 3 y2.
// sequence: progress at zero or at/above one goes straight to the output;
//   otherwise setup, then up to NEWTON_STEPS newton steps (cubic,
//   derivative, check, then the bit-serial divider), then up to
//   BISECT_STEPS bisection steps (cubic, check), then the cubic in y is
//   evaluated and y is rounded.
// all polynomial work runs through one multiply-accumulate unit, one horner
//   step per cycle; the newton quotient comes from the bit-serial divider.
// throughput: one item at a time, the next beat is taken in the cycle its
//   result appears; a finished result waits in its own state while the
//   output register is full and the receiver stalls.
// reset: control registers cleared, config set to ease (0.32,0.72,0.4,1.0).

module cubic_bezier_easing
  import cbe_pkg::*;
#(
  parameter int NEWTON_STEPS = 8,
  parameter int BISECT_STEPS = 40,
  parameter int FRAC_BITS    = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [FRAC_BITS+2:0]        cfg_data_i,
  input  logic                        progress_valid_i,
  output logic                        progress_stall_o,
  input  logic [FRAC_BITS:0]          progress_i,
  output logic                        eased_valid_o,
  input  logic                        eased_stall_i,
  output logic signed [FRAC_BITS+2:0] eased_o
);

  localparam int PW  = FRAC_BITS + 1;
  localparam int EW  = FRAC_BITS + 3;
  localparam int SH  = QB - FRAC_BITS;
  localparam int NCW = $clog2(NEWTON_STEPS + 1);
  localparam int BCW = $clog2(BISECT_STEPS + 1);
  localparam int TW  = QUO_BITS + 2;

  localparam logic [PW-1:0] ONE_IN = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] X1_RST = PW'((64'd20972 << FRAC_BITS) >> 16);
  localparam logic [EW-1:0] Y1_RST = EW'((64'd47186 << FRAC_BITS) >> 16);
  localparam logic [PW-1:0] X2_RST = PW'((64'd26214 << FRAC_BITS) >> 16);
  localparam logic [EW-1:0] Y2_RST = EW'((64'd65536 << FRAC_BITS) >> 16);
  localparam qv_t HALF    = qv_t'(1) <<< (SH - 1);
  localparam qv_t OUT_MAX = (qv_t'(1) <<< (EW - 1)) - qv_t'(1);
  localparam qv_t OUT_MIN = -(qv_t'(1) <<< (EW - 1));

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_CUB, S_DER, S_NCHK, S_NDIV, S_BCHK, S_RND, S_PUT
  } state_e;

  typedef enum logic [1:0] {
    M_NEWTON, M_BISECT, M_EVAL
  } mode_e;

  // configuration registers
  logic [PW-1:0] x1_q, x2_q;
  logic [EW-1:0] y1_q, y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_q <= X1_RST;
      y1_q <= Y1_RST;
      x2_q <= X2_RST;
      y2_q <= Y2_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_X1: x1_q <= cfg_data_i[PW-1:0];
        REG_Y1: y1_q <= cfg_data_i;
        REG_X2: x2_q <= cfg_data_i[PW-1:0];
        REG_Y2: y2_q <= cfg_data_i;
      endcase
    end
  end

  // control points in Q.28, x saturated to [0,1]
  logic [PW-1:0] x1c, x2c;
  qv_t x1q, x2q, y1q, y2q, dx, dy, x_in;

  assign x1c  = (x1_q > ONE_IN) ? ONE_IN : x1_q;
  assign x2c  = (x2_q > ONE_IN) ? ONE_IN : x2_q;
  assign x1q  = qv_t'(x1c) <<< SH;
  assign x2q  = qv_t'(x2c) <<< SH;
  assign y1q  = qv_t'($signed(y1_q)) <<< SH;
  assign y2q  = qv_t'($signed(y2_q)) <<< SH;
  assign dx   = x2q - x1q;
  assign dy   = y2q - y1q;
  assign x_in = qv_t'(progress_i) <<< SH;

  state_e state_q;
  mode_e  mode_q;
  logic [1:0]     ph_q;
  logic [NCW-1:0] n_cnt_q;
  logic [BCW-1:0] b_cnt_q;
  uq_t  u_q, lo_q, hi_q;
  qv_t  x_q, cx_q, d3x_q, cy_q, d3y_q;
  qv_t  ax_q, bx_q, ay_q, by_q, a3x_q, b2x_q;
  qv_t  fx_q;
  logic neg_q;
  logic [EW-1:0] res_q;
  logic          out_valid_q;
  logic [EW-1:0] eased_q;

  logic accept;
  assign accept = progress_valid_i && !progress_stall_o;

  // shared multiply-accumulate unit
  mac_ctl_t mac_ctl;
  qv_t mac_init, mac_add, acc;
  qv_t ca, cb, cc;

  assign ca = (mode_q == M_EVAL) ? ay_q : ax_q;
  assign cb = (mode_q == M_EVAL) ? by_q : bx_q;
  assign cc = (mode_q == M_EVAL) ? cy_q : cx_q;

  always_comb begin
    mac_ctl  = '{load: 1'b0, step: 1'b0};
    mac_init = ca;
    mac_add  = '0;
    unique case (state_q)
      S_CUB: begin
        unique case (ph_q)
          2'd0: mac_ctl.load = 1'b1;
          2'd1: begin
            mac_ctl.step = 1'b1;
            mac_add      = cb;
          end
          2'd2: begin
            mac_ctl.step = 1'b1;
            mac_add      = cc;
          end
          2'd3: mac_ctl.step = 1'b1;
        endcase
      end
      S_DER: begin
        mac_init = a3x_q;
        unique case (ph_q)
          2'd0: mac_ctl.load = 1'b1;
          2'd1: begin
            mac_ctl.step = 1'b1;
            mac_add      = b2x_q;
          end
          2'd2: begin
            mac_ctl.step = 1'b1;
            mac_add      = cx_q;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  cbe_mac u_cbe_mac (
    .clk_i    (clk_i),
    .ctl_i    (mac_ctl),
    .init_i   (mac_init),
    .addend_i (mac_add),
    .mult_i   (u_q),
    .acc_o    (acc)
  );

  // newton quotient
  logic         div_start;
  logic [W-1:0] fx_mag, d_mag;
  div_res_t     div_res;

  assign fx_mag    = fx_q[W-1] ? -fx_q : fx_q;
  assign d_mag     = acc[W-1] ? -acc : acc;
  assign div_start = (state_q == S_NCHK) && !abs_below_eps(fx_q) && !abs_below_eps(acc);

  cbe_div u_cbe_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (fx_mag),
    .den_i   (d_mag),
    .res_o   (div_res)
  );

  // u minus the quotient, saturated to [0,1]
  logic signed [TW-1:0] u_ext, q_ext, u_sum;
  uq_t u_new;

  assign u_ext = $signed({{(TW-QB-1){1'b0}}, u_q});
  assign q_ext = $signed({2'b00, div_res.quo});
  assign u_sum = neg_q ? (u_ext + q_ext) : (u_ext - q_ext);

  always_comb begin
    if (div_res.ovf) begin
      u_new = neg_q ? QONE[QB:0] : '0;
    end else if (u_sum < 0) begin
      u_new = '0;
    end else if (u_sum > TW'(QONE)) begin
      u_new = QONE[QB:0];
    end else begin
      u_new = u_sum[QB:0];
    end
  end

  // bisection update
  qv_t fb;
  uq_t lo_n, hi_n;
  logic [QB+1:0] mid_sum;

  assign fb      = acc - x_q;
  assign lo_n    = (acc < x_q) ? u_q : lo_q;
  assign hi_n    = (acc < x_q) ? hi_q : u_q;
  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};

  // output rounding
  qv_t r_sh;
  assign r_sh = (acc + HALF) >>> SH;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_NEWTON;
      ph_q        <= '0;
      n_cnt_q     <= '0;
      b_cnt_q     <= '0;
      u_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      x_q         <= '0;
      cx_q        <= '0;
      d3x_q       <= '0;
      cy_q        <= '0;
      d3y_q       <= '0;
      ax_q        <= '0;
      bx_q        <= '0;
      ay_q        <= '0;
      by_q        <= '0;
      a3x_q       <= '0;
      b2x_q       <= '0;
      fx_q        <= '0;
      neg_q       <= 1'b0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      eased_q     <= '0;
    end else begin
      if (out_valid_q && !eased_stall_i && (state_q != S_PUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (progress_i == '0) begin
              res_q   <= '0;
              state_q <= S_PUT;
            end else if (progress_i >= ONE_IN) begin
              res_q   <= EW'(ONE_IN);
              state_q <= S_PUT;
            end else begin
              x_q     <= x_in;
              cx_q    <= x1q + (x1q <<< 1);
              d3x_q   <= dx + (dx <<< 1);
              cy_q    <= y1q + (y1q <<< 1);
              d3y_q   <= dy + (dy <<< 1);
              state_q <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          ax_q    <= QONE - d3x_q;
          bx_q    <= d3x_q - cx_q;
          ay_q    <= QONE - d3y_q;
          by_q    <= d3y_q - cy_q;
          a3x_q   <= (QONE - d3x_q) + ((QONE - d3x_q) <<< 1);
          b2x_q   <= (d3x_q - cx_q) <<< 1;
          u_q     <= x_q[QB:0];
          n_cnt_q <= '0;
          mode_q  <= M_NEWTON;
          ph_q    <= '0;
          state_q <= S_CUB;
        end
        S_CUB: begin
          if (ph_q == 2'd3) begin
            ph_q <= '0;
            unique case (mode_q)
              M_NEWTON: state_q <= S_DER;
              M_BISECT: state_q <= S_BCHK;
              M_EVAL:   state_q <= S_RND;
              default:  state_q <= S_RND;
            endcase
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        S_DER: begin
          if (ph_q == 2'd0) begin
            fx_q <= acc - x_q;
          end
          if (ph_q == 2'd2) begin
            ph_q    <= '0;
            state_q <= S_NCHK;
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        S_NCHK: begin
          if (abs_below_eps(fx_q)) begin
            mode_q  <= M_EVAL;
            state_q <= S_CUB;
          end else if (abs_below_eps(acc)) begin
            lo_q    <= '0;
            hi_q    <= QONE[QB:0];
            u_q     <= x_q[QB:0];
            b_cnt_q <= '0;
            mode_q  <= M_BISECT;
            state_q <= S_CUB;
          end else begin
            neg_q   <= fx_q[W-1] ^ acc[W-1];
            state_q <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (div_res.done) begin
            if (n_cnt_q == NCW'(NEWTON_STEPS - 1)) begin
              lo_q    <= '0;
              hi_q    <= QONE[QB:0];
              u_q     <= x_q[QB:0];
              b_cnt_q <= '0;
              mode_q  <= M_BISECT;
            end else begin
              u_q     <= u_new;
              n_cnt_q <= n_cnt_q + 1'b1;
              mode_q  <= M_NEWTON;
            end
            state_q <= S_CUB;
          end
        end
        S_BCHK: begin
          if (abs_below_eps(fb)) begin
            mode_q <= M_EVAL;
          end else begin
            lo_q <= lo_n;
            hi_q <= hi_n;
            u_q  <= mid_sum[QB+1:1];
            if (b_cnt_q == BCW'(BISECT_STEPS - 1)) begin
              mode_q <= M_EVAL;
            end else begin
              b_cnt_q <= b_cnt_q + 1'b1;
            end
          end
          state_q <= S_CUB;
        end
        S_RND: begin
          if (r_sh > OUT_MAX) begin
            res_q <= OUT_MAX[EW-1:0];
          end else if (r_sh < OUT_MIN) begin
            res_q <= OUT_MIN[EW-1:0];
          end else begin
            res_q <= r_sh[EW-1:0];
          end
          state_q <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid_q || !eased_stall_i) begin
            eased_q     <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign progress_stall_o = (state_q != S_IDLE);
  assign eased_valid_o    = out_valid_q;
  assign eased_o          = $signed(eased_q);

endmodule

[rtl/cbe_checker.sv]
`timescale 1ns / 1ps
`include "cubic_bezier_easing_assert.svh"

module cbe_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [1:0]                  cfg_idx_i,
  input logic [FRAC_BITS+2:0]        cfg_data_i,
  input logic                        progress_valid_i,
  input logic                        progress_stall_o,
  input logic [FRAC_BITS:0]          progress_i,
  input logic                        eased_valid_o,
  input logic                        eased_stall_i,
  input logic signed [FRAC_BITS+2:0] eased_o
);

  logic in_beat;
  assign in_beat = progress_valid_i && !progress_stall_o;

  // stalled result beat holds
  `CBE_ASSERT(a_out_hold, eased_valid_o && eased_stall_i |=> eased_valid_o, "result beat dropped under stall")
  `CBE_ASSERT(a_out_stable, eased_valid_o && eased_stall_i |=> $stable(eased_o), "stalled result changed")
  // the block is busy once it takes a beat
  `CBE_ASSERT(a_busy, in_beat |=> progress_stall_o, "second beat taken while busy")
  // zero progress with a free output goes through the put state and shows zero
  `CBE_ASSERT(a_zero_fast, in_beat && progress_i == '0 && !eased_valid_o |-> ##2 (eased_valid_o && eased_o == '0), "zero progress result wrong or late")

endmodule

bind cubic_bezier_easing cbe_checker #(.FRAC_BITS(FRAC_BITS)) u_cbe_checker (.*);

[tb/sv/cbe_curve_checker.sv]
`timescale 1ns / 1ps

module cbe_curve_checker
  import cbe_pkg::*;
#(
  parameter int FB       = 16,
  parameter int NEWTON_N = 8,
  parameter int BISECT_N = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [FB+2:0]        cfg_data_i,
  input  logic                 progress_valid_i,
  input  logic                 progress_stall_i,
  input  logic [FB:0]          progress_i,
  input  logic                 eased_valid_i,
  input  logic                 eased_stall_i,
  input  logic signed [FB+2:0] eased_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  localparam int     SH     = QB - FB;
  localparam longint Q1     = longint'(QONE);
  localparam longint TOL    = longint'(EPS);
  localparam longint OUT_HI = (longint'(1) <<< (FB + 2)) - 1;
  localparam longint OUT_LO = -(longint'(1) <<< (FB + 2));

  localparam logic [FB:0]   X1_RST = 20972;
  localparam logic [FB+2:0] Y1_RST = 47186;
  localparam logic [FB:0]   X2_RST = 26214;
  localparam logic [FB+2:0] Y2_RST = 65536;

  logic [FB:0]          x1_r;
  logic [FB:0]          x2_r;
  logic [FB+2:0]        y1_r;
  logic [FB+2:0]        y2_r;
  logic signed [FB+2:0] eased_due[$];
  int                   fails = 0;
  int                   due_cnt;

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // product rounded toward minus infinity
  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> QB;
  endfunction

  function automatic longint cubic_at(longint a, longint b, longint c, longint u);
    return qmul(qmul(qmul(a, u) + b, u) + c, u);
  endfunction

  function automatic logic signed [FB+2:0] eased_for(logic [FB:0] p);
    longint x, qx1, qx2, qy1, qy2;
    longint ax, bx, cx, ay, by, cy;
    longint u, fx, d, lo, hi, y, r;
    bit     converged;
    if (p == 0) return '0;
    if (p >= (1 << FB)) return (FB + 3)'(1 << FB);

    x   = longint'(p) <<< SH;
    qx1 = sat(longint'(x1_r) <<< SH, 0, Q1);
    qx2 = sat(longint'(x2_r) <<< SH, 0, Q1);
    qy1 = sat(longint'($signed(y1_r)) <<< SH, -4 * Q1, 4 * Q1);
    qy2 = sat(longint'($signed(y2_r)) <<< SH, -4 * Q1, 4 * Q1);

    cx = 3 * qx1;
    bx = 3 * (qx2 - qx1) - cx;
    ax = Q1 - cx - bx;
    cy = 3 * qy1;
    by = 3 * (qy2 - qy1) - cy;
    ay = Q1 - cy - by;

    // newton from u = x
    u = x;
    converged = 1'b0;
    for (int i = 0; i < NEWTON_N; i++) begin
      fx = cubic_at(ax, bx, cx, u) - x;
      d  = qmul(qmul(3 * ax, u) + 2 * bx, u) + cx;
      if (fx < TOL && fx > -TOL) begin
        converged = 1'b1;
        break;
      end
      if (d < TOL && d > -TOL) break;
      u = sat(u - (fx * Q1) / d, 0, Q1);
    end

    // bisection fallback, restarting from u = x
    if (!converged) begin
      lo = 0;
      hi = Q1;
      u  = x;
      for (int i = 0; i < BISECT_N; i++) begin
        fx = cubic_at(ax, bx, cx, u);
        if (fx - x < TOL && fx - x > -TOL) break;
        if (fx < x) lo = u;
        else hi = u;
        u = (lo + hi) >>> 1;
      end
    end

    y = cubic_at(ay, by, cy, u);
    r = (y + (longint'(1) <<< (SH - 1))) >>> SH;
    r = sat(r, OUT_LO, OUT_HI);
    return r[FB+2:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [FB+2:0] want;
    if (!rst_ni) begin
      x1_r = X1_RST;
      y1_r = Y1_RST;
      x2_r = X2_RST;
      y2_r = Y2_RST;
      eased_due.delete();
      due_cnt <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_X1: x1_r = cfg_data_i[FB:0];
          REG_Y1: y1_r = cfg_data_i;
          REG_X2: x2_r = cfg_data_i[FB:0];
          REG_Y2: y2_r = cfg_data_i;
          default: ;
        endcase
      end
      if (eased_valid_i && !eased_stall_i) begin
        if (eased_due.size() == 0) begin
          $error("eased: unexpected beat, expected none, got %0d", eased_i);
          fails++;
        end else begin
          want = eased_due.pop_front();
          if (eased_i !== want) begin
            $error("eased: expected %0d, got %0d", want, eased_i);
            fails++;
          end
        end
      end
      if (progress_valid_i && !progress_stall_i) eased_due.push_back(eased_for(progress_i));
      due_cnt <= eased_due.size();
    end
  end

  assign fail_count_o = fails;
  assign pending_o    = due_cnt;

endmodule

[tb/sv/tb_cubic_bezier_easing.sv]
`timescale 1ns / 1ps

module tb_cubic_bezier_easing;
  import cbe_pkg::*;

  localparam int FB    = 16;
  localparam int ITEMS = 1950;
  localparam int TAIL  = 600;

  // register values: zero, one, most negative and most positive y
  localparam logic [FB+2:0] V_ZERO = '0;
  localparam logic [FB+2:0] V_ONE  = (FB + 3)'(1) << FB;
  localparam logic [FB+2:0] V_YMIN = (FB + 3)'(1) << (FB + 2);
  localparam logic [FB+2:0] V_YMAX = V_YMIN - (FB + 3)'(1);

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [1:0]           cfg_idx_i;
  logic [FB+2:0]        cfg_data_i;
  logic                 progress_valid_i;
  logic                 progress_stall_o;
  logic [FB:0]          progress_i;
  logic                 eased_valid_o;
  logic                 eased_stall_i;
  logic signed [FB+2:0] eased_o;

  int fail_count;
  int pending;
  int sent;
  bit send_quiet;
  bit recv_quiet;

  cubic_bezier_easing u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .progress_valid_i (progress_valid_i),
    .progress_stall_o (progress_stall_o),
    .progress_i       (progress_i),
    .eased_valid_o    (eased_valid_o),
    .eased_stall_i    (eased_stall_i),
    .eased_o          (eased_o)
  );

  cbe_curve_checker #(.FB(FB)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .progress_valid_i (progress_valid_i),
    .progress_stall_i (progress_stall_o),
    .progress_i       (progress_i),
    .eased_valid_i    (eased_valid_o),
    .eased_stall_i    (eased_stall_i),
    .eased_i          (eased_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("cubic_bezier_easing test failed");
    $finish;
  end

  task automatic push_progress(input logic [FB:0] val);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      progress_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    progress_valid_i <= 1'b1;
    progress_i       <= val;
    do @(posedge clk_i); while (progress_stall_o);
    sent++;
  endtask

  // hold off until every beat in flight has come back
  task automatic drain();
    progress_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [FB+2:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_curve(input logic [FB+2:0] x1, input logic [FB+2:0] y1,
                           input logic [FB+2:0] x2, input logic [FB+2:0] y2);
    drain();
    write_reg(REG_X1, x1);
    write_reg(REG_Y1, y1);
    write_reg(REG_X2, x2);
    write_reg(REG_Y2, y2);
  endtask

  function automatic logic [FB+2:0] rand_x();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = 0;
      2:       v = 1 << FB;
      default: v = $urandom_range(0, 1 << FB);
    endcase
    return v[FB+2:0];
  endfunction

  function automatic logic [FB+2:0] rand_y();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = $urandom;
      1:       v = 1 << (FB + 2);
      2:       v = (1 << (FB + 2)) - 1;
      default: v = $urandom_range(0, 5 << FB) - (2 << FB);
    endcase
    return v[FB+2:0];
  endfunction

  function automatic logic [FB:0] rand_progress();
    int unsigned sel;
    logic [31:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 3) v = 0;
    else if (sel < 7) v = $urandom_range(1 << FB, (2 << FB) - 1);
    else if (sel == 7) v = 1;
    else if (sel == 8) v = (1 << FB) - 1;
    else v = $urandom_range(1, (1 << FB) - 1);
    return v[FB:0];
  endfunction

  initial begin
    int corner_pts[10];
    int mid_pts[3];
    int n;
    corner_pts = '{0, 1 << FB, (1 << FB) + 1, (2 << FB) - 1, 1, (1 << FB) - 1,
                   1 << (FB - 1), 'h15555, 'h0aaaa, 'h05555};
    mid_pts    = '{1, 21845, (1 << FB) - 1};

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_X1;
    cfg_data_i       = '0;
    progress_valid_i = 1'b0;
    progress_i       = '0;
    eased_stall_i    = 1'b0;
    send_quiet       = 1'b0;
    recv_quiet       = 1'b0;
    sent             = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset curve, corners of the progress range
    foreach (corner_pts[i]) push_progress(corner_pts[i][FB:0]);

    // flat start, linear output
    set_curve(V_ZERO, V_ZERO, V_ONE, V_ONE);
    foreach (mid_pts[i]) push_progress(mid_pts[i][FB:0]);
    // crossed control x, extreme y
    set_curve(V_ONE, V_YMIN, V_ZERO, V_YMAX);
    foreach (mid_pts[i]) push_progress(mid_pts[i][FB:0]);
    // control x above one, flat end
    set_curve('1, V_YMAX, '1, V_YMIN);
    foreach (mid_pts[i]) push_progress(mid_pts[i][FB:0]);
    // pure cube in x
    set_curve(V_ZERO, V_ONE, V_ZERO, V_ZERO);
    foreach (mid_pts[i]) push_progress(mid_pts[i][FB:0]);

    while (sent < ITEMS) begin
      set_curve(rand_x(), rand_y(), rand_x(), rand_y());
      send_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 200);
      repeat (n) begin
        if (sent >= ITEMS) break;
        if ($urandom_range(0, 49) == 0) drain();
        push_progress(rand_progress());
      end
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("cubic_bezier_easing test passed");
    end else begin
      $display("cubic_bezier_easing test failed");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int hold;
    int beats;
    beats = 0;
    @(posedge rst_ni);
    forever begin
      if (beats % 64 == 0) recv_quiet = ($urandom_range(0, 3) == 0);
      hold = recv_quiet ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        eased_stall_i <= 1'b1;
        do @(posedge clk_i); while (!eased_valid_o);
        repeat (hold - 1) @(posedge clk_i);
      end
      eased_stall_i <= 1'b0;
      do @(posedge clk_i); while (!eased_valid_o);
      beats++;
    end
  end

endmodule
